>>> sv/amtw_pkg.sv
// Shared constants for the adaptive mean threshold window unit.
package amtw_pkg;

    localparam int KERNEL_SIZE_DEF    = 7;
    localparam int MAX_LINE_WIDTH_DEF = 2048;

    localparam int PIX_W      = 8;
    localparam int WORD_W     = 32;
    localparam int COL_W      = 12;
    localparam int OFFSET_W   = 9;
    localparam int FG_W       = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 4;

    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(4095);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MEAN_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FOREGROUND  = CFG_IDX_W'(1);

    localparam logic signed [OFFSET_W-1:0] MEAN_OFFSET_RST = OFFSET_W'(2);
    localparam logic [FG_W-1:0]            FOREGROUND_RST  = FG_W'(255);

endpackage

>>> sv/amtw_line_store.sv
// One bank of the line store: single write port, single registered read port.
module amtw_line_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [amtw_pkg::PIX_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [amtw_pkg::PIX_W-1:0] rd_data
);
    logic [amtw_pkg::PIX_W-1:0] mem [DEPTH];
    logic [amtw_pkg::PIX_W-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/amtw_threshold.sv
// Local mean by reciprocal multiply and the foreground decision.
module amtw_threshold #(
    parameter int TOTAL_W = 14,
    parameter int DIVISOR = 49
) (
    input  logic [TOTAL_W-1:0]                   total,
    input  logic [amtw_pkg::PIX_W-1:0]           centre,
    input  logic signed [amtw_pkg::OFFSET_W-1:0] mean_offset,
    input  logic [amtw_pkg::FG_W-1:0]            foreground_value,
    output logic [amtw_pkg::FG_W-1:0]            level
);
    import amtw_pkg::*;

    // exact floor(total / DIVISOR) for every TOTAL_W-bit total
    localparam int SHIFT   = TOTAL_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
    localparam int RECIP_W = TOTAL_W + 1;
    localparam int PROD_W  = TOTAL_W + RECIP_W;
    localparam int MEAN_W  = PROD_W - SHIFT;
    localparam int CMP_W   = MEAN_W + 2;

    logic [PROD_W-1:0]       product;
    logic [MEAN_W-1:0]       mean;
    logic signed [CMP_W-1:0] lhs;
    logic signed [CMP_W-1:0] rhs;

    assign product = PROD_W'(total) * PROD_W'(RECIP_W'(RECIP));
    assign mean    = product[PROD_W-1:SHIFT];

    // centre > mean - offset, rearranged to avoid a negative limit
    assign lhs   = $signed(CMP_W'({1'b0, centre})) + CMP_W'(mean_offset);
    assign rhs   = $signed(CMP_W'({1'b0, mean}));
    assign level = (lhs > rhs) ? foreground_value : '0;

endmodule

>>> sv/adaptive_mean_threshold_window_unit.sv
// Adaptive mean threshold over a square window of a pixel stream.
// Stages: line store read, window, threshold, each ending in a register.
// One word per cycle unless out_ready stalls; a word reads all banks and writes one.
// Reset clears counters, window, column sums and pipeline valids, and loads the
// register defaults (offset 2, foreground 255). Line banks are not cleared.
module adaptive_mean_threshold_window_unit #(
    parameter int KERNEL_SIZE    = amtw_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_LINE_WIDTH = amtw_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [amtw_pkg::WORD_W-1:0]     pixel_word,
    input  logic                            frame_start,
    input  logic                            line_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [amtw_pkg::WORD_W-1:0]     result_word,
    output logic                            out_frame_start,
    output logic                            out_line_end,
    input  logic                            cfg_wr_en,
    input  logic [amtw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [amtw_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import amtw_pkg::*;

    localparam int K      = KERNEL_SIZE;
    localparam int NB     = K - 1;
    localparam int ADDR_W = $clog2(MAX_LINE_WIDTH);
    localparam int RW     = $clog2(K);
    localparam int SW     = $clog2(NB);
    localparam int CS_W   = $clog2(K * 255 + 1);
    localparam int TW     = $clog2(K * K * 255 + 1);
    localparam int CMP_W  = COL_W + 1;
    localparam int ALPHA_W = WORD_W - 3 * PIX_W;

    // configuration
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [FG_W-1:0]            fg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= MEAN_OFFSET_RST;
            fg_reg     <= FOREGROUND_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_IDX_MEAN_OFFSET)
            begin
                offset_reg <= $signed(cfg_wr_data[OFFSET_W-1:0]);
            end
            else if (cfg_index == CFG_IDX_FOREGROUND)
            begin
                fg_reg <= cfg_wr_data[FG_W-1:0];
            end
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic ld_out, ld2, ld1, accept;

    assign ld_out   = !out_valid_reg || out_ready;
    assign ld2      = !s2_valid_reg || ld_out;
    assign ld1      = !s1_valid_reg || ld2;
    assign in_ready = ld1;
    assign accept   = in_valid && ld1;

    // position counters
    logic [COL_W-1:0] col_reg, col_next, eff_col;
    logic [RW-1:0]    row_reg, row_next, eff_row;
    logic [SW-1:0]    slot_reg, slot_next, eff_slot;
    logic             in_range;

    always_comb
    begin
        eff_col  = frame_start ? '0 : col_reg;
        eff_row  = frame_start ? '0 : row_reg;
        eff_slot = frame_start ? '0 : slot_reg;
        in_range = {1'b0, eff_col} < CMP_W'(MAX_LINE_WIDTH);
        col_next  = eff_col;
        row_next  = eff_row;
        slot_next = eff_slot;
        if (line_end)
        begin
            col_next = '0;
            if (eff_row < RW'(K - 1))
            begin
                row_next = eff_row + RW'(1);
            end
            slot_next = (eff_slot == SW'(NB - 1)) ? '0 : eff_slot + SW'(1);
        end
        else if (eff_col < COL_LIMIT)
        begin
            col_next = eff_col + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // line banks, one per stored row
    logic [PIX_W-1:0] rd_data [NB];

    for (genvar b = 0; b < NB; b++)
    begin : g_bank
        amtw_line_store #(
            .DEPTH  (MAX_LINE_WIDTH),
            .ADDR_W (ADDR_W)
        ) u_bank (
            .clk     (clk),
            .wr_en   (accept && in_range && (eff_slot == SW'(b))),
            .wr_addr (eff_col[ADDR_W-1:0]),
            .wr_data (pixel_word[PIX_W-1:0]),
            .rd_en   (accept && in_range),
            .rd_addr (eff_col[ADDR_W-1:0]),
            .rd_data (rd_data[b])
        );
    end

    // stage 1: word alongside the bank read
    logic [PIX_W-1:0]   s1_grey_reg;
    logic [ALPHA_W-1:0] s1_alpha_reg;
    logic               s1_fs_reg, s1_le_reg, s1_in_range_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [RW-1:0]      s1_row_reg;
    logic [SW-1:0]      s1_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ld1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_grey_reg     <= pixel_word[PIX_W-1:0];
            s1_alpha_reg    <= pixel_word[WORD_W-1 -: ALPHA_W];
            s1_fs_reg       <= frame_start;
            s1_le_reg       <= line_end;
            s1_in_range_reg <= in_range;
            s1_col_reg      <= eff_col;
            s1_row_reg      <= eff_row;
            s1_slot_reg     <= eff_slot;
        end
    end

    // window, column sums and running total
    logic [PIX_W-1:0] win_reg  [K][K];
    logic [PIX_W-1:0] win_next [K][K];
    logic [CS_W-1:0]  sums_reg  [K];
    logic [CS_W-1:0]  sums_next [K];
    logic [TW-1:0]    total_reg, total_next;
    logic [CS_W-1:0]  fresh;
    logic [SW:0]      slot_sum [NB];
    logic [SW-1:0]    slot_idx [NB];
    logic             col0;
    logic             win_adv;

    assign win_adv = s1_valid_reg && ld2;
    assign col0    = (s1_col_reg == '0);

    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            slot_sum[i] = {1'b0, s1_slot_reg} + (SW + 1)'(i);
            if (slot_sum[i] >= (SW + 1)'(NB))
            begin
                slot_sum[i] = slot_sum[i] - (SW + 1)'(NB);
            end
            slot_idx[i] = slot_sum[i][SW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < K; i++)
        begin
            for (int j = 0; j < K - 1; j++)
            begin
                win_next[i][j] = win_reg[i][j+1];
            end
            win_next[i][K-1] = win_reg[i][K-1];
        end
        // fill the right column from the banks; hold it past the line limit
        if (s1_in_range_reg)
        begin
            for (int i = 0; i < K - 1; i++)
            begin
                if (s1_row_reg < RW'(K - 1 - i))
                begin
                    win_next[i][K-1] = (s1_row_reg == '0) ? s1_grey_reg : rd_data[0];
                end
                else
                begin
                    win_next[i][K-1] = rd_data[slot_idx[i]];
                end
            end
            win_next[K-1][K-1] = s1_grey_reg;
        end
        // replicate the right column into columns left of the frame
        for (int i = 0; i < K; i++)
        begin
            for (int j = 0; j < K - 1; j++)
            begin
                if (s1_col_reg < COL_W'(K - 1 - j))
                begin
                    win_next[i][j] = win_next[i][K-1];
                end
            end
        end
    end

    always_comb
    begin
        fresh = '0;
        for (int i = 0; i < K; i++)
        begin
            fresh = fresh + CS_W'(win_next[i][K-1]);
        end
        total_next = (col0 ? '0 : total_reg) + TW'(fresh) - (col0 ? '0 : TW'(sums_reg[0]));
        for (int i = 0; i < K - 1; i++)
        begin
            sums_next[i] = col0 ? '0 : sums_reg[i+1];
        end
        sums_next[K-1] = fresh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < K; i++)
            begin
                for (int j = 0; j < K; j++)
                begin
                    win_reg[i][j] <= '0;
                end
                sums_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (win_adv)
        begin
            win_reg   <= win_next;
            sums_reg  <= sums_next;
            total_reg <= total_next;
        end
    end

    // stage 2: total and centre
    logic [TW-1:0]      s2_total_reg;
    logic [PIX_W-1:0]   s2_centre_reg;
    logic [ALPHA_W-1:0] s2_alpha_reg;
    logic               s2_fs_reg, s2_le_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (ld2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_adv)
        begin
            s2_total_reg  <= total_next;
            s2_centre_reg <= win_next[K/2][K/2];
            s2_alpha_reg  <= s1_alpha_reg;
            s2_fs_reg     <= s1_fs_reg;
            s2_le_reg     <= s1_le_reg;
        end
    end

    logic [FG_W-1:0] level;

    amtw_threshold #(
        .TOTAL_W (TW),
        .DIVISOR (K * K)
    ) u_threshold (
        .total            (s2_total_reg),
        .centre           (s2_centre_reg),
        .mean_offset      (offset_reg),
        .foreground_value (fg_reg),
        .level            (level)
    );

    // output register
    logic [WORD_W-1:0] out_word_reg;
    logic              out_fs_reg, out_le_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out && s2_valid_reg)
        begin
            out_word_reg <= {s2_alpha_reg, level, level, level};
            out_fs_reg   <= s2_fs_reg;
            out_le_reg   <= s2_le_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_word     = out_word_reg;
    assign out_frame_start = out_fs_reg;
    assign out_line_end    = out_le_reg;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the adaptive mean threshold window unit.
`timescale 1ns / 100ps

module testbench;

    import amtw_pkg::*;

    localparam int KERNEL      = KERNEL_SIZE_DEF;
    localparam int MAX_W       = MAX_LINE_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;

    // index that decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_IDX_W'(15);

    typedef struct packed {
        logic [WORD_W-1:0] rgba;
        logic              sof;
        logic              eol;
    } pixel_out_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              sof;
        logic              eol;
        logic              typed;
        logic [WORD_W-1:0] typed_word;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [WORD_W-1:0]     pixel_word;
    logic                  frame_start;
    logic                  line_end;
    logic                  out_valid;
    logic                  out_ready;
    logic [WORD_W-1:0]     result_word;
    logic                  out_frame_start;
    logic                  out_line_end;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    adaptive_mean_threshold_window_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_word      (pixel_word),
        .frame_start     (frame_start),
        .line_end        (line_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_word     (result_word),
        .out_frame_start (out_frame_start),
        .out_line_end    (out_line_end),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    // threshold model state
    int         mean_offset_q;
    logic [7:0] foreground_q;
    int         col_pos;
    int         row_pos;
    int         line_slot;
    logic [7:0] line_mem [KERNEL-1][MAX_W];
    logic [7:0] win [KERNEL][KERNEL];
    int         col_sum [KERNEL];
    int         win_total;

    pixel_out_t pending_pixels [$];
    int         mismatch_count;
    int         cycle_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         hold_pending;
    int         hold_left;
    pixel_out_t got_pixel;
    pixel_out_t want_pixel;

    stim_row_t directed_rows [24] = '{
        {32'h12345600, 1'b0, 1'b0, 1'b1, 32'h12FFFFFF},
        {32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 32'hFFFFFFFF},
        {32'h00000000, 1'b1, 1'b0, 1'b1, 32'h00FFFFFF},
        {32'h5A5A5AFF, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'hA5A5A580, 1'b0, 1'b1, 1'b0, 32'h0},
        {32'hFF0000FE, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'h00FFFF01, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'h7F00007F, 1'b0, 1'b1, 1'b0, 32'h0},
        {32'h80FFFF80, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'h01010110, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'hFE0000F0, 1'b0, 1'b1, 1'b0, 32'h0},
        {32'h3C3C3C40, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'hC3C3C3C0, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'h0F0F0F20, 1'b0, 1'b1, 1'b0, 32'h0},
        {32'hF0F0F0E0, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'h55555560, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'hAAAAAA70, 1'b0, 1'b1, 1'b0, 32'h0},
        {32'h00000090, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'hFFFFFF00, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'h12345678, 1'b0, 1'b1, 1'b0, 32'h0},
        {32'h9ABCDEF0, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'h0000007F, 1'b0, 1'b0, 1'b0, 32'h0},
        {32'hFFFFFF81, 1'b0, 1'b1, 1'b0, 32'h0},
        {32'h800000C8, 1'b0, 1'b1, 1'b0, 32'h0}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Compute the thresholded word for one input word and advance the model.
    task automatic threshold_pixel(input logic [WORD_W-1:0] word, input logic sof,
                                   input logic eol, output pixel_out_t res);
        logic [7:0] grey;
        logic [7:0] pick;
        logic [7:0] border;
        logic [7:0] fg;
        int         sl;
        int         fresh;
        int         mean;
        int         limit;
        int         centre;
        grey = word[7:0];
        if (sof)
        begin
            col_pos   = 0;
            row_pos   = 0;
            line_slot = 0;
        end
        if (col_pos == 0)
        begin
            win_total = 0;
            foreach (col_sum[i])
                col_sum[i] = 0;
        end
        for (int i = 0; i < KERNEL; i++)
            for (int j = 0; j < KERNEL - 1; j++)
                win[i][j] = win[i][j + 1];
        if (col_pos < MAX_W)
        begin
            for (int i = 0; i < KERNEL - 1; i++)
            begin
                sl = (line_slot + i) % (KERNEL - 1);
                // rows above the frame take the top row
                if (row_pos + i < KERNEL - 1)
                    pick = (row_pos == 0) ? grey : line_mem[0][col_pos];
                else
                    pick = line_mem[sl][col_pos];
                win[i][KERNEL - 1] = pick;
            end
            win[KERNEL - 1][KERNEL - 1] = grey;
            line_mem[line_slot][col_pos] = grey;
        end
        // replicate the newest column into columns left of the frame
        for (int i = 0; i < KERNEL; i++)
        begin
            border = win[i][KERNEL - 1];
            for (int j = 0; j < KERNEL - 1; j++)
                if (col_pos + j < KERNEL - 1)
                    win[i][j] = border;
        end
        fresh = 0;
        for (int i = 0; i < KERNEL; i++)
            fresh += win[i][KERNEL - 1];
        win_total = win_total + fresh - col_sum[0];
        for (int i = 0; i < KERNEL - 1; i++)
            col_sum[i] = col_sum[i + 1];
        col_sum[KERNEL - 1] = fresh;

        mean   = win_total / (KERNEL * KERNEL);
        limit  = mean - mean_offset_q;
        centre = win[KERNEL / 2][KERNEL / 2];
        fg     = (centre > limit) ? foreground_q : 8'h00;
        res.rgba = {word[31:24], fg, fg, fg};
        res.sof  = sof;
        res.eol  = eol;

        if (eol)
        begin
            col_pos = 0;
            if (row_pos < KERNEL - 1)
                row_pos++;
            line_slot = (line_slot + 1) % (KERNEL - 1);
        end
        else if (col_pos < int'(COL_LIMIT))
        begin
            col_pos++;
        end
    endtask

    // Offer one word, wait for acceptance, then queue its expected result.
    task automatic send_pixel(input logic [WORD_W-1:0] word, input logic sof, input logic eol,
                              input logic typed, input logic [WORD_W-1:0] typed_word);
        pixel_out_t want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_word  <= word;
        frame_start <= sof;
        line_end    <= eol;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        threshold_pixel(word, sof, eol, want);
        if (typed)
            want.rgba = typed_word;
        pending_pixels.push_back(want);
    endtask

    // Drop valid and hold until every queued result has come out.
    task automatic wait_for_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_IDX_MEAN_OFFSET)
            mean_offset_q = int'($signed(data[OFFSET_W-1:0]));
        else if (idx == CFG_IDX_FOREGROUND)
            foreground_q = data[FG_W-1:0];
    endtask

    // Random frames: rows never wider than the row above, so the line banks
    // are only read where written; now and then a frame is dropped mid-row.
    task automatic stream_frames(input int item_goal);
        int          sent;
        int          width;
        int          rows;
        int          cut;
        int          base;
        int          grey;
        bit          abandon;
        logic [31:0] word;
        sent = 0;
        while (sent < item_goal)
        begin
            case ($urandom_range(9))
                0:       width = $urandom_range(1, 3);
                1, 2:    width = $urandom_range(13, 40);
                default: width = $urandom_range(4, 12);
            endcase
            rows    = $urandom_range(1, 10);
            base    = $urandom_range(255);
            abandon = 1'b0;
            for (int r = 0; r < rows && !abandon; r++)
            begin
                if ($urandom_range(7) == 0)
                    width = $urandom_range(1, width);
                cut = ($urandom_range(24) == 0) ? $urandom_range(1, width) : 0;
                for (int c = 0; c < width; c++)
                begin
                    word = $urandom;
                    // keep grey near the frame level so the offset decides
                    if ($urandom_range(1) == 1)
                    begin
                        grey = base + int'($urandom_range(16)) - 8;
                        if (grey < 0)
                            grey = 0;
                        if (grey > 255)
                            grey = 255;
                        word[7:0] = grey[7:0];
                    end
                    send_pixel(word, r == 0 && c == 0, c == width - 1, 1'b0, '0);
                    sent++;
                    if (c + 1 == cut && c != width - 1)
                    begin
                        abandon = 1'b1;
                        break;
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input pixel_out_t want,
                                   input pixel_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected word %h sof %b eol %b, got word %h sof %b eol %b",
                     $realtime, what, want.rgba, want.sof, want.eol,
                     got.rgba, got.sof, got.eol);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_pixel = {result_word, out_frame_start, out_line_end};
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("unexpected word", '0, got_pixel);
            end
            else
            begin
                want_pixel = pending_pixels.pop_front();
                if (got_pixel.rgba !== want_pixel.rgba)
                    report_mismatch("result_word", want_pixel, got_pixel);
                else if (got_pixel.sof !== want_pixel.sof)
                    report_mismatch("out_frame_start", want_pixel, got_pixel);
                else if (got_pixel.eol !== want_pixel.eol)
                    report_mismatch("out_line_end", want_pixel, got_pixel);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pixel_word     = '0;
        frame_start    = 1'b0;
        line_end       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wr_data    = '0;
        hold_pending   = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 22;
        recv_idle_pct  = 64;

        mean_offset_q = int'(MEAN_OFFSET_RST);
        foreground_q  = FOREGROUND_RST;
        col_pos       = 0;
        row_pos       = 0;
        line_slot     = 0;
        win_total     = 0;
        foreach (line_mem[i, j])
            line_mem[i][j] = 8'h00;
        foreach (win[i, j])
            win[i][j] = 8'h00;
        foreach (col_sum[i])
            col_sum[i] = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset state, edge replication, row counter saturation
        foreach (directed_rows[n])
            send_pixel(directed_rows[n].word, directed_rows[n].sof, directed_rows[n].eol,
                       directed_rows[n].typed, directed_rows[n].typed_word);
        wait_for_idle();

        write_reg(CFG_IDX_MEAN_OFFSET, CFG_DATA_W'(0));
        write_reg(CFG_IDX_FOREGROUND, CFG_DATA_W'(8'h5A));
        stream_frames(150);
        wait_for_idle();

        send_idle_pct = 64;
        recv_idle_pct = 22;
        write_reg(CFG_IDX_MEAN_OFFSET, CFG_DATA_W'(-255));
        write_reg(CFG_IDX_FOREGROUND, CFG_DATA_W'(0));
        stream_frames(100);
        wait_for_idle();

        // the top data bit does not reach the foreground register
        write_reg(CFG_IDX_MEAN_OFFSET, CFG_DATA_W'(255));
        write_reg(CFG_IDX_FOREGROUND, 9'h1FF);
        write_reg(CFG_IDX_UNUSED, 9'h1AB);
        stream_frames(150);
        wait_for_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_IDX_MEAN_OFFSET, CFG_DATA_W'(-3));
        write_reg(CFG_IDX_FOREGROUND, CFG_DATA_W'(8'hC3));
        // hold the output long enough for the input to back up
        hold_pending = 1'b1;
        stream_frames(250);
        wait_for_idle();

        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
sv/amtw_pkg.sv
sv/amtw_line_store.sv
sv/amtw_threshold.sv
sv/adaptive_mean_threshold_window_unit.sv
test/testbench.sv
